// ===== rtl/core/amtd_pkg.sv =====
// ----------------------------------------------------------------------------
// amtd_pkg
// Shared widths, register indexes, reset values and types for the
// accelerometer motion tamper detector.
// ----------------------------------------------------------------------------
package amtd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int THRESH_W  = 16;
    localparam int SUM_W     = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam int WINDOW_SAMPLES_DEF  = 11;
    localparam int DISCARD_SAMPLES_DEF = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_Z = 2'd2;

    localparam logic [THRESH_W-1:0] THRESH_X_RST = 16'd41;
    localparam logic [THRESH_W-1:0] THRESH_Y_RST = 16'd41;
    localparam logic [THRESH_W-1:0] THRESH_Z_RST = 16'd328;

    // per-word control from the window sequencer to the axis lanes
    typedef struct packed {
        logic advance;
        logic keep;
        logic done;
    } step_t;

endpackage

// ===== rtl/core/amtd_window.sv =====
// ----------------------------------------------------------------------------
// amtd_window
// Window position counter: marks discarded leading words and the word that
// closes each window.
// ----------------------------------------------------------------------------
module amtd_window #(
    parameter int WINDOW_SAMPLES  = amtd_pkg::WINDOW_SAMPLES_DEF,
    parameter int DISCARD_SAMPLES = amtd_pkg::DISCARD_SAMPLES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    output amtd_pkg::step_t step
);

    localparam int POS_W = $clog2(WINDOW_SAMPLES);
    localparam int CNT_MAX = (WINDOW_SAMPLES > DISCARD_SAMPLES) ?
                             WINDOW_SAMPLES : DISCARD_SAMPLES;
    localparam int CNT_W = $clog2(CNT_MAX + 1);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             done;
    logic             keep;

    assign done = (pos_reg == POS_W'(WINDOW_SAMPLES - 1));
    assign keep = (CNT_W'(pos_reg) >= CNT_W'(DISCARD_SAMPLES));

    always_comb
    begin
        pos_next = pos_reg;
        if (advance)
        begin
            pos_next = done ? '0 : pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    assign step.advance = advance;
    assign step.keep    = keep;
    assign step.done    = done;

endmodule

// ===== rtl/core/amtd_axis.sv =====
// ----------------------------------------------------------------------------
// amtd_axis
// One axis lane: previous sample, absolute change, saturating window sum
// and limit compare.
// ----------------------------------------------------------------------------
module amtd_axis #(
    parameter int LIMIT_W = amtd_pkg::THRESH_W + 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  amtd_pkg::step_t                   step,
    input  logic signed [amtd_pkg::SAMPLE_W-1:0] sample,
    input  logic [LIMIT_W-1:0]                limit,
    output logic [amtd_pkg::SUM_W-1:0]        sum,
    output logic                              over
);

    localparam int SW    = amtd_pkg::SAMPLE_W;
    localparam int SUM_W = amtd_pkg::SUM_W;
    localparam int CMP_W = (LIMIT_W > SUM_W) ? LIMIT_W : SUM_W;

    logic signed [SW-1:0] prev_reg;
    logic [SUM_W-1:0]     acc_reg;
    logic [SUM_W-1:0]     acc_next;
    logic signed [SW:0]   diff;
    logic [SW-1:0]        delta;
    logic [SUM_W:0]       raw_sum;
    logic [SUM_W-1:0]     sat_sum;

    assign diff    = {sample[SW-1], sample} - {prev_reg[SW-1], prev_reg};
    assign delta   = diff[SW] ? SW'(-diff) : diff[SW-1:0];
    assign raw_sum = {1'b0, acc_reg} + (SUM_W+1)'(delta);
    assign sat_sum = raw_sum[SUM_W] ? amtd_pkg::SUM_MAX : raw_sum[SUM_W-1:0];

    assign sum  = step.keep ? sat_sum : acc_reg;
    assign over = (CMP_W'(sum) > CMP_W'(limit));

    always_comb
    begin
        acc_next = acc_reg;
        if (step.advance)
        begin
            acc_next = step.done ? '0 : sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (step.advance)
            begin
                prev_reg <= sample;
            end
        end
    end

endmodule

// ===== rtl/core/accel_motion_tamper_detect_unit.sv =====
// ----------------------------------------------------------------------------
// accel_motion_tamper_detect_unit
// Flags tamper when the mean absolute sample-to-sample change of all three
// accelerometer axes exceeds its threshold over a window.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (accel_x/y/z) arrive on in_valid/in_ready; one result word
//   per input word leaves on out_valid/out_ready (window_done, tamper and
//   the three change sums, which read zero unless window_done is set).
//   Thresholds are written through cfg_we/cfg_index/cfg_data while idle;
//   index 3 is ignored. Each write also loads the kept-count times
//   threshold limit used by the compare.
//   Path: an accepted word lands in the input register; its result is
//   loaded into the output register once that register is free or read,
//   and out_valid then rises.
//   Throughput: one word per cycle while out_ready stays high; the path from
//   input register to output register is abs-diff, saturating add and limit compare.
//   When the receiver stalls, the output word holds and at most one more input
//   word is taken into the input register before in_ready drops.
//   Reset clears the valid flags of both pipeline stages, the previous
//   sample, the window sums and position, and restores the threshold defaults.
// ----------------------------------------------------------------------------
module accel_motion_tamper_detect_unit #(
    parameter int WINDOW_SAMPLES  = amtd_pkg::WINDOW_SAMPLES_DEF,
    parameter int DISCARD_SAMPLES = amtd_pkg::DISCARD_SAMPLES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [amtd_pkg::SAMPLE_W-1:0]  accel_x,
    input  logic signed [amtd_pkg::SAMPLE_W-1:0]  accel_y,
    input  logic signed [amtd_pkg::SAMPLE_W-1:0]  accel_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  window_done,
    output logic                                  tamper,
    output logic [amtd_pkg::SUM_W-1:0]            change_sum_x,
    output logic [amtd_pkg::SUM_W-1:0]            change_sum_y,
    output logic [amtd_pkg::SUM_W-1:0]            change_sum_z,
    input  logic                                  cfg_we,
    input  logic [amtd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [amtd_pkg::THRESH_W-1:0]         cfg_data
);

    localparam int SW      = amtd_pkg::SAMPLE_W;
    localparam int SUM_W   = amtd_pkg::SUM_W;
    localparam int KEPT    = (WINDOW_SAMPLES > DISCARD_SAMPLES) ?
                             (WINDOW_SAMPLES - DISCARD_SAMPLES) : 0;
    localparam int LIMIT_W = amtd_pkg::THRESH_W + $clog2(WINDOW_SAMPLES + 1);

    localparam logic [LIMIT_W-1:0] LIMIT_X_RST =
        LIMIT_W'(amtd_pkg::THRESH_X_RST) * LIMIT_W'(KEPT);
    localparam logic [LIMIT_W-1:0] LIMIT_Y_RST =
        LIMIT_W'(amtd_pkg::THRESH_Y_RST) * LIMIT_W'(KEPT);
    localparam logic [LIMIT_W-1:0] LIMIT_Z_RST =
        LIMIT_W'(amtd_pkg::THRESH_Z_RST) * LIMIT_W'(KEPT);

    logic [LIMIT_W-1:0] limit_x_reg;
    logic [LIMIT_W-1:0] limit_y_reg;
    logic [LIMIT_W-1:0] limit_z_reg;
    logic [LIMIT_W-1:0] cfg_limit;

    logic                 a_valid_reg;
    logic signed [SW-1:0] a_x_reg;
    logic signed [SW-1:0] a_y_reg;
    logic signed [SW-1:0] a_z_reg;
    logic                 advance;

    logic             out_valid_reg;
    logic             window_done_reg;
    logic             tamper_reg;
    logic [SUM_W-1:0] sum_x_reg;
    logic [SUM_W-1:0] sum_y_reg;
    logic [SUM_W-1:0] sum_z_reg;

    amtd_pkg::step_t  step;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [SUM_W-1:0] sum_z;
    logic             over_x;
    logic             over_y;
    logic             over_z;

    assign advance  = a_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !a_valid_reg || advance;

    // threshold times kept-window count
    assign cfg_limit = LIMIT_W'(cfg_data) * LIMIT_W'(KEPT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_x_reg <= LIMIT_X_RST;
            limit_y_reg <= LIMIT_Y_RST;
            limit_z_reg <= LIMIT_Z_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                amtd_pkg::CFG_THRESH_X: limit_x_reg <= cfg_limit;
                amtd_pkg::CFG_THRESH_Y: limit_y_reg <= cfg_limit;
                amtd_pkg::CFG_THRESH_Z: limit_z_reg <= cfg_limit;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_x_reg <= accel_x;
            a_y_reg <= accel_y;
            a_z_reg <= accel_z;
        end
    end

    amtd_window #(
        .WINDOW_SAMPLES  (WINDOW_SAMPLES),
        .DISCARD_SAMPLES (DISCARD_SAMPLES)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .step    (step)
    );

    amtd_axis #(.LIMIT_W(LIMIT_W)) u_axis_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .sample (a_x_reg),
        .limit  (limit_x_reg),
        .sum    (sum_x),
        .over   (over_x)
    );

    amtd_axis #(.LIMIT_W(LIMIT_W)) u_axis_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .sample (a_y_reg),
        .limit  (limit_y_reg),
        .sum    (sum_y),
        .over   (over_y)
    );

    amtd_axis #(.LIMIT_W(LIMIT_W)) u_axis_z (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .sample (a_z_reg),
        .limit  (limit_z_reg),
        .sum    (sum_z),
        .over   (over_z)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            window_done_reg <= step.done;
            tamper_reg      <= step.done && over_x && over_y && over_z;
            sum_x_reg       <= step.done ? sum_x : '0;
            sum_y_reg       <= step.done ? sum_y : '0;
            sum_z_reg       <= step.done ? sum_z : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign window_done  = window_done_reg;
    assign tamper       = tamper_reg;
    assign change_sum_x = sum_x_reg;
    assign change_sum_y = sum_y_reg;
    assign change_sum_z = sum_z_reg;

endmodule

// ===== rtl/core/amtd_checker.sv =====
// ----------------------------------------------------------------------------
// amtd_checker
// Port-level checks for the motion tamper detector, bound to the top level.
// ----------------------------------------------------------------------------
module amtd_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_ready,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic                                  window_done,
    input logic                                  tamper,
    input logic [amtd_pkg::SUM_W-1:0]            change_sum_x,
    input logic [amtd_pkg::SUM_W-1:0]            change_sum_y,
    input logic [amtd_pkg::SUM_W-1:0]            change_sum_z
);

    // tamper only on a word that closes a window
    a_tamper_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tamper |-> window_done)
        else $error("tamper without window_done");

    // sums read zero outside a closing word
    a_sums_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !window_done |->
            change_sum_x == '0 && change_sum_y == '0 && change_sum_z == '0)
        else $error("nonzero sums on open window");

    // input backpressure only while the output word waits
    a_ready_low_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low with free output");

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(window_done)
            && $stable(tamper) && $stable(change_sum_x)
            && $stable(change_sum_y) && $stable(change_sum_z))
        else $error("output word changed while stalled");

endmodule

bind accel_motion_tamper_detect_unit amtd_checker u_amtd_checker (.*);

// ===== dv/tb_accel_motion_tamper_detect_unit.sv =====
// ----------------------------------------------------------------------------
// tb_accel_motion_tamper_detect_unit
// Self-checking bench for the motion tamper detector. A built-in window
// predictor tracks the previous sample, the kept change sums and the window
// position, and queues one expected result word per accepted input word.
// Stimulus is a short run of full-scale swings, then random windows built
// around the programmed thresholds under several threshold settings, with
// bursty input, a patterned output stall and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_accel_motion_tamper_detect_unit;

    localparam int SAMPLE_W            = amtd_pkg::SAMPLE_W;
    localparam int THRESH_W            = amtd_pkg::THRESH_W;
    localparam int SUM_W               = amtd_pkg::SUM_W;
    localparam int CFG_IDX_W           = amtd_pkg::CFG_IDX_W;
    localparam int WINDOW_SAMPLES_DEF  = amtd_pkg::WINDOW_SAMPLES_DEF;
    localparam int DISCARD_SAMPLES_DEF = amtd_pkg::DISCARD_SAMPLES_DEF;

    localparam logic [SUM_W-1:0]     SUM_MAX      = amtd_pkg::SUM_MAX;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_X = amtd_pkg::CFG_THRESH_X;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_Y = amtd_pkg::CFG_THRESH_Y;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_Z = amtd_pkg::CFG_THRESH_Z;
    localparam logic [THRESH_W-1:0]  THRESH_X_RST = amtd_pkg::THRESH_X_RST;
    localparam logic [THRESH_W-1:0]  THRESH_Y_RST = amtd_pkg::THRESH_Y_RST;
    localparam logic [THRESH_W-1:0]  THRESH_Z_RST = amtd_pkg::THRESH_Z_RST;

    localparam int WINDOW = WINDOW_SAMPLES_DEF;
    localparam int KEPT = (WINDOW_SAMPLES_DEF > DISCARD_SAMPLES_DEF) ?
                          (WINDOW_SAMPLES_DEF - DISCARD_SAMPLES_DEF) : 0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic             done;
        logic             tamper;
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [SUM_W-1:0] sum_z;
    } motion_result_t;

    typedef enum int {STY_EDGE, STY_WILD, STY_STILL, STY_JITTER} axis_style_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_QUARTER, RX_MOSTLY} rx_pattern_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic                       out_valid;
    logic                       out_ready;
    logic                       window_done;
    logic                       tamper;
    logic [SUM_W-1:0]           change_sum_x;
    logic [SUM_W-1:0]           change_sum_y;
    logic [SUM_W-1:0]           change_sum_z;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [THRESH_W-1:0]        cfg_data;

    // predictor state
    logic signed [SAMPLE_W-1:0] last_smp [3];
    logic [SUM_W-1:0]           change_acc [3];
    logic [THRESH_W-1:0]        limit_thresh [3];
    int                         win_count;

    motion_result_t pending_results [$];

    int errors          = 0;
    int words_sent      = 0;
    int burst_left      = 0;
    int hold_off_cycles = 0;
    int cycle_count     = 0;
    bit sender_no_gaps  = 1'b0;

    accel_motion_tamper_detect_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .window_done  (window_done),
        .tamper       (tamper),
        .change_sum_x (change_sum_x),
        .change_sum_y (change_sum_y),
        .change_sum_z (change_sum_z),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void reset_motion_model();
        for (int a = 0; a < 3; a++)
        begin
            last_smp[a]   = '0;
            change_acc[a] = '0;
        end
        limit_thresh[0] = THRESH_X_RST;
        limit_thresh[1] = THRESH_Y_RST;
        limit_thresh[2] = THRESH_Z_RST;
        win_count = 0;
    endfunction

    function automatic motion_result_t predict_motion(
        input logic signed [SAMPLE_W-1:0] sx,
        input logic signed [SAMPLE_W-1:0] sy,
        input logic signed [SAMPLE_W-1:0] sz
    );
        logic signed [SAMPLE_W-1:0] smp [3];
        logic signed [SAMPLE_W:0]   diff;
        logic [SAMPLE_W-1:0]        mag;
        logic [SUM_W:0]             total;
        logic                       over_all;
        motion_result_t             res;
        smp[0] = sx;
        smp[1] = sy;
        smp[2] = sz;
        res = '0;
        over_all = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            diff = smp[a] - last_smp[a];
            mag = (diff < 0) ? SAMPLE_W'(-diff) : SAMPLE_W'(diff);
            last_smp[a] = smp[a];
            if (win_count >= DISCARD_SAMPLES_DEF)
            begin
                total = {1'b0, change_acc[a]} + mag;
                change_acc[a] = (total > {1'b0, SUM_MAX}) ? SUM_MAX : total[SUM_W-1:0];
            end
        end
        win_count++;
        if (win_count >= WINDOW_SAMPLES_DEF)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (!(longint'(change_acc[a]) > longint'(KEPT) * longint'(limit_thresh[a])))
                    over_all = 1'b0;
            end
            res.done   = 1'b1;
            res.tamper = over_all;
            res.sum_x  = change_acc[0];
            res.sum_y  = change_acc[1];
            res.sum_z  = change_acc[2];
            for (int a = 0; a < 3; a++)
                change_acc[a] = '0;
            win_count = 0;
        end
        return res;
    endfunction

    task automatic check_field(input string what, input longint want, input longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // prediction on input handshake, compare on output handshake
    always @(posedge clk)
    begin
        motion_result_t want;
        motion_result_t fresh;
        if (rst_n && in_valid && in_ready)
        begin
            fresh = predict_motion(accel_x, accel_y, accel_z);
            pending_results.insert(pending_results.size(), fresh);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual done=%0d tamper=%0d",
                         $time, window_done, tamper);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("window_done", want.done, window_done);
                check_field("tamper", want.tamper, tamper);
                check_field("change_sum_x", want.sum_x, change_sum_x);
                check_field("change_sum_y", want.sum_y, change_sum_y);
                check_field("change_sum_z", want.sum_z, change_sum_z);
            end
        end
    end

    // receiver: shifting stall patterns, plus a hold-off counted here
    initial
    begin
        rx_pattern_t pattern;
        int          pattern_left;
        int          tick;
        pattern      = RX_OPEN;
        pattern_left = 0;
        tick         = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern      = rx_pattern_t'($urandom_range(0, 3));
                    pattern_left = $urandom_range(16, 120);
                end
                pattern_left--;
                case (pattern)
                    RX_OPEN:    out_ready <= 1'b1;
                    RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
                    RX_QUARTER: out_ready <= ((tick % 4) == 0);
                    default:    out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_sample(
        input logic signed [SAMPLE_W-1:0] x,
        input logic signed [SAMPLE_W-1:0] y,
        input logic signed [SAMPLE_W-1:0] z
    );
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (sender_no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        accel_x  <= x;
        accel_y  <= y;
        accel_z  <= z;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [THRESH_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_THRESH_X: limit_thresh[0] = val;
            CFG_THRESH_Y: limit_thresh[1] = val;
            CFG_THRESH_Z: limit_thresh[2] = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_limits(input int tx, input int ty, input int tz);
        drain_results();
        write_limit(CFG_THRESH_X, THRESH_W'(tx));
        write_limit(CFG_THRESH_Y, THRESH_W'(ty));
        write_limit(CFG_THRESH_Z, THRESH_W'(tz));
    endtask

    // windows aligned to the block's window position; about half of the axes step by
    // exactly threshold-1, threshold or threshold+1 so the compare edge is hit
    task automatic run_random_windows(input int n_words);
        int          sent;
        int          len;
        int          r;
        axis_style_t sty [3];
        int          base [3];
        int          delta [3];
        int          v [3];
        sent = 0;
        while (sent < n_words)
        begin
            len = WINDOW - (words_sent % WINDOW);
            for (int a = 0; a < 3; a++)
            begin
                r = $urandom_range(0, 9);
                sty[a] = (r < 5) ? STY_EDGE : (r < 7) ? STY_WILD :
                         (r < 8) ? STY_STILL : STY_JITTER;
                delta[a] = int'(limit_thresh[a]) + int'($urandom_range(0, 2)) - 1;
                if (delta[a] < 0)
                    delta[a] = 0;
                if (delta[a] > 65535)
                    delta[a] = 65535;
                if (sty[a] == STY_EDGE)
                    base[a] = int'($urandom_range(0, 65535 - delta[a])) - 32768;
                else
                    base[a] = int'($urandom_range(0, 64000)) - 32000;
                if (sty[a] == STY_JITTER)
                    delta[a] = $urandom_range(1, 64);
            end
            for (int i = 0; i < len; i++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    case (sty[a])
                        STY_EDGE:   v[a] = base[a] + ((i % 2) ? delta[a] : 0);
                        STY_WILD:   v[a] = $urandom_range(0, 65535);
                        STY_STILL:  v[a] = base[a];
                        default:    v[a] = base[a] + int'($urandom_range(0, 2 * delta[a]))
                                           - delta[a];
                    endcase
                end
                send_sample(16'(v[0]), 16'(v[1]), 16'(v[2]));
                sent++;
            end
        end
    endtask

    // full-scale swings from a zero previous sample, then near-still samples
    task automatic test_extreme_swings();
        for (int i = 0; i < 2 * WINDOW; i++)
        begin
            if (i < WINDOW)
                send_sample((i % 2) ? 16'sh7FFF : 16'sh8000,
                            (i % 2) ? 16'sh8000 : 16'sh7FFF,
                            (i % 2) ? 16'sh7FFF : 16'sh8000);
            else
                send_sample(16'sh0000, (i % 2) ? 16'shFFFF : 16'sh0000, 16'shFFFF);
        end
    endtask

    task automatic test_default_thresholds();
        run_random_windows(140);
    endtask

    task automatic test_zero_thresholds();
        set_limits(0, 0, 0);
        run_random_windows(110);
    endtask

    task automatic test_max_thresholds();
        set_limits(65535, 65535, 65535);
        run_random_windows(100);
    endtask

    task automatic test_output_backpressure();
        set_limits($urandom_range(1, 400), $urandom_range(1, 400), $urandom_range(1, 400));
        sender_no_gaps = 1'b1;
        hold_off_cycles = 60;
        run_random_windows(48);
        sender_no_gaps = 1'b0;
        run_random_windows(100);
    endtask

    task automatic test_drain_midwindow();
        run_random_windows(35);
        drain_results();
        run_random_windows(35);
    endtask

    task automatic test_unmapped_index();
        set_limits($urandom_range(0, 300), $urandom_range(0, 300), $urandom_range(0, 3000));
        write_limit(CFG_SPARE, THRESH_W'($urandom_range(0, 65535)));
        run_random_windows(100);
    endtask

    task automatic test_random_thresholds();
        for (int p = 0; p < 3; p++)
        begin
            if (p == 0)
                set_limits($urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 65535));
            else
                set_limits($urandom_range(0, 2000), $urandom_range(0, 2000),
                           $urandom_range(0, 2000));
            run_random_windows(80);
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        accel_x   <= '0;
        accel_y   <= '0;
        accel_z   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_THRESH_X;
        cfg_data  <= '0;
        reset_motion_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_extreme_swings();
        test_default_thresholds();
        test_zero_thresholds();
        test_max_thresholds();
        test_output_backpressure();
        test_drain_midwindow();
        test_unmapped_index();
        test_random_thresholds();
        drain_results();

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
